// File: sv/md4_pkg.sv
// Shared types, constants and control store for the MD4 hash engine.
package md4_pkg;

  localparam int unsigned CntW = 61;
  localparam int unsigned PcW  = 6;

  localparam logic [PcW-1:0] PC_ROUND0 = 6'd0;
  localparam logic [PcW-1:0] PC_FINAL  = 6'd48;
  localparam logic [PcW-1:0] PC_IDLE   = 6'd49;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K_R2 = 32'h5A827999;
  localparam logic [31:0] K_R3 = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  POS_MASK = 6'h3F;
  localparam logic [5:0]  LEN_POS  = 6'd56;

  localparam logic [4:0] R1_SHIFT [4] = '{5'd3, 5'd7, 5'd11, 5'd19};
  localparam logic [4:0] R2_SHIFT [4] = '{5'd3, 5'd5, 5'd9, 5'd13};
  localparam logic [4:0] R3_SHIFT [4] = '{5'd3, 5'd9, 5'd11, 5'd15};

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_ROUND,
    OP_FINAL
  } op_e;

  typedef enum logic [1:0] {
    RND_F,
    RND_G,
    RND_H
  } rnd_e;

  typedef struct packed {
    op_e        op;
    rnd_e       fsel;
    logic [3:0] widx;
    logic [4:0] shamt;
  } ctrl_t;

  typedef struct packed {
    logic        pad;
    logic        blk2;
    logic [5:0]  pos;
    logic [63:0] bitlen;
  } pad_ctl_t;

  function automatic ctrl_t ctrl_rom(input logic [PcW-1:0] pc);
    ctrl_t      c;
    logic [3:0] j;
    logic [1:0] r;
    j = pc[3:0];
    r = pc[5:4];
    c = '{op: OP_IDLE, fsel: RND_F, widx: 4'd0, shamt: 5'd0};
    if (pc < PC_FINAL) begin
      c.op = OP_ROUND;
      unique case (r)
        2'd0: begin
          c.fsel  = RND_F;
          c.widx  = j;
          c.shamt = R1_SHIFT[j[1:0]];
        end
        2'd1: begin
          c.fsel  = RND_G;
          c.widx  = {j[1:0], j[3:2]};
          c.shamt = R2_SHIFT[j[1:0]];
        end
        default: begin
          c.fsel  = RND_H;
          c.widx  = {j[0], j[1], j[2], j[3]};
          c.shamt = R3_SHIFT[j[1:0]];
        end
      endcase
    end else if (pc == PC_FINAL) begin
      c.op = OP_FINAL;
    end
    return c;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rnd_fn(input rnd_e sel, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (sel)
      RND_F:   f = (b & c) | (~b & d);
      RND_G:   f = (b & c) | (b & d) | (c & d);
      RND_H:   f = b ^ c ^ d;
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rnd_k(input rnd_e sel);
    logic [31:0] k;
    unique case (sel)
      RND_F:   k = 32'd0;
      RND_G:   k = K_R2;
      RND_H:   k = K_R3;
      default: k = 32'd0;
    endcase
    return k;
  endfunction

endpackage

// File: sv/md4_in_if.sv
// Input channel: one message byte or end-of-message marker per transfer.
interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// File: sv/md4_out_if.sv
// Output channel: one digest word per transfer.
interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/md4_msgbuf.sv
// Block buffer with byte writes and padded message word reads.
module md4_msgbuf (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [5:0]        wr_pos_i,
  input  logic [7:0]        wr_byte_i,
  input  logic [3:0]        rd_idx_i,
  input  md4_pkg::pad_ctl_t ctl_i,
  output logic [31:0]       word_o
);

  logic [31:0] mem_q [16];
  logic [31:0] raw;
  logic        len_here;
  logic [5:0]  bpos [4];
  logic [5:0]  lsel [4];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_pos_i[5:2]][{wr_pos_i[1:0], 3'b000} +: 8] <= wr_byte_i;
    end
  end

  assign raw      = mem_q[rd_idx_i];
  assign len_here = ctl_i.pad && (ctl_i.blk2 || (ctl_i.pos < md4_pkg::LEN_POS));

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      bpos[l] = {rd_idx_i, 2'(l)};
      lsel[l] = {rd_idx_i[0], 2'(l), 3'b000};
      if (!ctl_i.pad) begin
        word_o[8*l +: 8] = raw[8*l +: 8];
      end else if (len_here && (bpos[l] >= md4_pkg::LEN_POS)) begin
        word_o[8*l +: 8] = ctl_i.bitlen[lsel[l] +: 8];
      end else if (!ctl_i.blk2 && (bpos[l] < ctl_i.pos)) begin
        word_o[8*l +: 8] = raw[8*l +: 8];
      end else if (!ctl_i.blk2 && (bpos[l] == ctl_i.pos)) begin
        word_o[8*l +: 8] = md4_pkg::PAD_BYTE;
      end else begin
        word_o[8*l +: 8] = 8'h00;
      end
    end
  end

endmodule

// File: sv/md4_hash_engine.sv
// MD4 hash engine top level: control store sequencer and compression datapath.
//
// Input channel in_i carries one item per transfer: data_byte with byte_valid,
// and end_of_message to close the message. Output channel out_o carries the
// four digest words, word_index 0 to 3, last_word set on the fourth.
// A byte is taken while the engine is idle. The 64th byte of a
// block starts the 48-step compression, one step per cycle from a 50-entry
// control store, plus a final step for the chaining add; no input is taken
// during these. End of message runs one or two padded compressions with
// padding and length inserted on the read side of the block buffer, then
// loads the digest into an output register bank and returns to idle.
// The bank drains one word per transfer while the next message streams in;
// a following digest waits in the final step until the bank is empty.
// Reset restores the initial chaining values and a zero byte count.
module md4_hash_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  md4_in_if.sink     in_i,
  md4_out_if.source  out_o
);

  md4_pkg::ctrl_t                cw;
  md4_pkg::pad_ctl_t             pctl;
  logic [md4_pkg::PcW-1:0]       pc_q, pc_d;
  logic [md4_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          pad_q, pad_d;
  logic                          blk2_q, blk2_d;
  logic                          eom_q, eom_d;
  logic [31:0]                   chain_q [4];
  logic [31:0]                   chain_d [4];
  logic [31:0]                   dig_q [4];
  logic [31:0]                   dig_d [4];
  logic [31:0]                   sum [4];
  logic [31:0]                   wa_q, wa_d, wb_q, wb_d, wc_q, wc_d, wd_q, wd_d;
  logic                          ovld_q, ovld_d;
  logic [1:0]                    oidx_q, oidx_d;
  logic                          in_fire, out_fire;
  logic [5:0]                    pos;
  logic [31:0]                   xw, nv;

  assign cw       = md4_pkg::ctrl_rom(pc_q);
  assign pos      = cnt_q[5:0] & md4_pkg::POS_MASK;
  assign in_i.ready = (cw.op == md4_pkg::OP_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign pctl.pad    = pad_q;
  assign pctl.blk2   = blk2_q;
  assign pctl.pos    = pos;
  assign pctl.bitlen = {cnt_q, 3'b000};

  md4_msgbuf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && in_i.byte_valid),
    .wr_pos_i  (pos),
    .wr_byte_i (in_i.data_byte),
    .rd_idx_i  (cw.widx),
    .ctl_i     (pctl),
    .word_o    (xw)
  );

  assign nv = md4_pkg::rotl32(wa_q + md4_pkg::rnd_fn(cw.fsel, wb_q, wc_q, wd_q) + xw
                              + md4_pkg::rnd_k(cw.fsel), cw.shamt);

  assign sum[0] = chain_q[0] + wa_q;
  assign sum[1] = chain_q[1] + wb_q;
  assign sum[2] = chain_q[2] + wc_q;
  assign sum[3] = chain_q[3] + wd_q;

  assign out_o.valid       = ovld_q;
  assign out_o.digest_word = dig_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == 2'd3);

  always_comb begin
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    blk2_d  = blk2_q;
    eom_d   = eom_q;
    chain_d = chain_q;
    dig_d   = dig_q;
    wa_d    = wa_q;
    wb_d    = wb_q;
    wc_d    = wc_q;
    wd_d    = wd_q;
    ovld_d  = ovld_q;
    oidx_d  = oidx_q;

    if (out_fire) begin
      if (oidx_q == 2'd3) begin
        ovld_d = 1'b0;
      end else begin
        oidx_d = oidx_q + 2'd1;
      end
    end

    unique case (cw.op)
      md4_pkg::OP_IDLE: begin
        if (in_fire) begin
          if (in_i.byte_valid) begin
            cnt_d = cnt_q + md4_pkg::CntW'(1);
          end
          if (in_i.byte_valid && (pos == md4_pkg::POS_MASK)) begin
            pc_d  = md4_pkg::PC_ROUND0;
            pad_d = 1'b0;
            eom_d = in_i.end_of_message;
            wa_d  = chain_q[0];
            wb_d  = chain_q[1];
            wc_d  = chain_q[2];
            wd_d  = chain_q[3];
          end else if (in_i.end_of_message) begin
            pc_d   = md4_pkg::PC_ROUND0;
            pad_d  = 1'b1;
            blk2_d = 1'b0;
            wa_d   = chain_q[0];
            wb_d   = chain_q[1];
            wc_d   = chain_q[2];
            wd_d   = chain_q[3];
          end
        end
      end
      md4_pkg::OP_ROUND: begin
        wa_d = wd_q;
        wb_d = nv;
        wc_d = wb_q;
        wd_d = wc_q;
        pc_d = pc_q + md4_pkg::PcW'(1);
      end
      md4_pkg::OP_FINAL: begin
        if (!pad_q) begin
          chain_d = sum;
          if (eom_q) begin
            pc_d   = md4_pkg::PC_ROUND0;
            pad_d  = 1'b1;
            blk2_d = 1'b0;
            eom_d  = 1'b0;
            wa_d   = sum[0];
            wb_d   = sum[1];
            wc_d   = sum[2];
            wd_d   = sum[3];
          end else begin
            pc_d = md4_pkg::PC_IDLE;
          end
        end else if (!blk2_q && (pos >= md4_pkg::LEN_POS)) begin
          chain_d = sum;
          blk2_d  = 1'b1;
          pc_d    = md4_pkg::PC_ROUND0;
          wa_d    = sum[0];
          wb_d    = sum[1];
          wc_d    = sum[2];
          wd_d    = sum[3];
        end else if (!ovld_q) begin
          dig_d      = sum;
          ovld_d     = 1'b1;
          oidx_d     = 2'd0;
          chain_d[0] = md4_pkg::IV0;
          chain_d[1] = md4_pkg::IV1;
          chain_d[2] = md4_pkg::IV2;
          chain_d[3] = md4_pkg::IV3;
          cnt_d      = '0;
          pad_d      = 1'b0;
          blk2_d     = 1'b0;
          pc_d       = md4_pkg::PC_IDLE;
        end
      end
      default: begin
        pc_d = md4_pkg::PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= md4_pkg::PC_IDLE;
      cnt_q      <= '0;
      pad_q      <= 1'b0;
      blk2_q     <= 1'b0;
      eom_q      <= 1'b0;
      chain_q[0] <= md4_pkg::IV0;
      chain_q[1] <= md4_pkg::IV1;
      chain_q[2] <= md4_pkg::IV2;
      chain_q[3] <= md4_pkg::IV3;
      ovld_q     <= 1'b0;
      oidx_q     <= 2'd0;
    end else begin
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
      blk2_q  <= blk2_d;
      eom_q   <= eom_d;
      chain_q <= chain_d;
      ovld_q  <= ovld_d;
      oidx_q  <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    wc_q  <= wc_d;
    wd_q  <= wd_d;
  end

`ifndef SYNTHESIS
  a_blk2_in_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk2_q |-> pad_q)
    else $error("second padding block outside padding");

  a_plain_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op != md4_pkg::OP_IDLE) && !pad_q |-> (pos == 6'd0))
    else $error("data block compressed at unaligned count");

  a_word_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (oidx_q != 2'd3) |=> ovld_q && (oidx_q == $past(oidx_q) + 2'd1))
    else $error("digest word index did not advance");

  a_eom_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eom_q |-> !pad_q)
    else $error("pending end of message during padding");
`endif

endmodule
